>>> hdl/cgr_pkg.sv
// Shared types and constants of the co-occurrence graph rank unit.
`timescale 1ns / 1ps
`default_nettype none

package cgr_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAST_DELTA    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_COUNT      = 3'd4;

  localparam logic [4:0]  RST_WINDOW_LENGTH  = 5'd5;
  localparam logic [15:0] RST_DAMPING        = 16'd55706;
  localparam logic [9:0]  RST_MAX_ITERATIONS = 10'd100;
  localparam logic [15:0] RST_LEAST_DELTA    = 16'd7;
  localparam logic [6:0]  RST_TOP_COUNT      = 7'd10;

  // Arithmetic constants
  localparam logic [31:0] ONE_Q16       = 32'h0001_0000;
  localparam logic [16:0] ONE_Q16_17    = 17'h1_0000;
  localparam logic [15:0] WEIGHT_MAX    = 16'hFFFF;
  localparam logic [23:0] SCORE_MAX_24  = 24'hFF_FFFF;
  localparam logic [31:0] SCORE_MAX_32  = 32'hFFFF_FFFF;
  localparam logic [6:0]  TOP_LIMIT     = 7'd64;

  // Input beat
  typedef struct packed {
    logic [31:0] word_key;
    logic        end_of_document;
  } cgr_in_t;

  // Output beat
  typedef struct packed {
    logic [31:0] ranked_key;
    logic [23:0] rank_score;
    logic [5:0]  rank_position;
    logic        table_overflowed;
    logic        final_entry;
  } cgr_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic idle;
    logic take;
    logic clr_step;
    logic srch_rd;
    logic scan_inc;
    logic hit;
    logic add_key;
    logic set_ovf;
    logic win_rd;
    logic win_skip;
    logic win_bump;
    logic shift;
    logic sum_init;
    logic pair_rd_ij;
    logic sum_acc;
    logic sum_wr;
    logic it_init;
    logic it_rd;
    logic mul;
    logic div_start;
    logic acc_add;
    logic j_step;
    logic nv_rd;
    logic nv_wr;
    logic iter_end;
    logic sel_init;
    logic sel_rd;
    logic sel_cmp;
    logic out_rd;
    logic out_load;
    logic doc_clear;
  } cgr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic scan_end;
    logic key_match;
    logic full;
    logic win_end;
    logic win_same;
    logic eod;
    logic i_last;
    logic j_last;
    logic term_ok;
    logic div_done;
    logic iter_zero;
    logic iter_stop;
    logic p_last;
    logic out_free;
  } cgr_sts_t;

endpackage

`default_nettype wire

>>> hdl/cooccurrence_graph_rank_unit.sv
// Top level of the co-occurrence graph rank unit (keyword ranking over one document).
// Input channel: one word key per beat, end_of_document set on the last token.
// Output channel: after the last token, min(top_count clamped to 1..64, distinct
// words) beats in descending score order, final_entry set on the last one. Tokens
// are taken one at a time: in_stall_o is high from the cycle after the accepted
// beat until that token is filed. After the accept, the token is compared with
// each stored key in turn, then each window pair is bumped by a read and a write
// of the single-port pair-weight RAM; window entries of the same word are skipped.
// Document end: weight sums, then rank rounds with one run of the 48-step serial
// divider per nonzero pair term (zero terms skip it), then one selection scan
// per result. The next document waits for these phases.
// Reset and every document end run a clearing pass over the pair-weight RAM of
// 2^(2*ceil(log2 MAX_WORDS)) entries (4096 at 64 words) with in_stall_o high.
// A stalled receiver holds the result register; ranking pauses only when the
// next result is ready and the register is still full. Configuration writes are
// taken in any cycle and must only happen while the unit is idle.
`timescale 1ns / 1ps
`default_nettype none

module cooccurrence_graph_rank_unit #(
  parameter int MAX_WORDS  = 64,
  parameter int MAX_WINDOW = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [cgr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [cgr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire cgr_pkg::cgr_in_t               in_beat_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      cgr_pkg::cgr_out_t              out_beat_o
);

  import cgr_pkg::*;

  cgr_cmd_t cmd;
  cgr_sts_t sts;

  cgr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cgr_datapath #(
    .MAX_WORDS  (MAX_WORDS),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_beat_i   (in_beat_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // Accept a beat only in the idle state
  assign in_stall_o = !cmd.idle;

`ifndef SYNTHESIS
  // A pending result is never overwritten
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("result register loaded while full");

  // A divider start clears its done flag
  a_div_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> !sts.div_done)
    else $error("divider done flag survived a start");

  // One token at a time
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second token accepted while the first is in work");
`endif

endmodule

`default_nettype wire

>>> hdl/cgr_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module cgr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one word and read one word per cycle, at the same address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

>>> hdl/cgr_div.sv
// Restoring divider, one quotient bit per cycle, low 32 quotient bits kept.
`timescale 1ns / 1ps
`default_nettype none

module cgr_div #(
  parameter int DVD_W = 48,
  parameter int DSR_W = 22
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DSR_W-1:0] divisor_i,
  output      logic             done_o,
  output      logic [31:0]      quot_o
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_q;
  logic [DSR_W-1:0] dsr_q;
  logic [DSR_W-1:0] rem_q;
  logic [31:0]      quot_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DSR_W:0]   trial;
  logic             ge;
  logic [DSR_W:0]   diff;

  // Trial subtract of the divisor
  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  // Control: busy for DVD_W steps, then done until the next start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CW'(1);
      if (cnt_q == CW'(DVD_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Datapath: shift in one dividend bit a step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= dividend_i;
      dsr_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      dvd_q  <= {dvd_q[DVD_W-2:0], 1'b0};
      rem_q  <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      quot_q <= {quot_q[30:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

>>> hdl/cgr_datapath.sv
// Datapath: tables, graph weights, score buffers, arithmetic and result register.
`timescale 1ns / 1ps
`default_nettype none

module cgr_datapath #(
  parameter int MAX_WORDS  = 64,
  parameter int MAX_WINDOW = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [cgr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [cgr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire cgr_pkg::cgr_in_t                 in_beat_i,
  input  wire logic                             out_stall_i,
  output      logic                             out_valid_o,
  output      cgr_pkg::cgr_out_t                out_beat_o,
  input  wire cgr_pkg::cgr_cmd_t                cmd_i,
  output      cgr_pkg::cgr_sts_t                sts_o
);

  import cgr_pkg::*;

  localparam int VW   = $clog2(MAX_WORDS);
  localparam int RW   = $clog2(MAX_WINDOW);
  localparam int PAW  = 2 * VW;
  localparam int PDEP = 1 << PAW;
  localparam int SW   = 16 + VW;
  localparam int AW   = 32 + VW;
  localparam int PW   = 16 + AW;
  localparam int MW   = 48;
  localparam int SPW  = (RW + 1 > 6) ? RW + 1 : 6;
  localparam int CNTW = (VW + 1 > 7) ? VW + 1 : 7;

  // Configuration registers
  logic [4:0]  wl_q;
  logic [15:0] damp_q;
  logic [9:0]  maxit_q;
  logic [15:0] least_q;
  logic [6:0]  topc_q;

  // Token state
  logic [31:0]   key_q;
  logic          eod_q;
  logic [VW:0]   vc_q;
  logic [VW:0]   scan_q;
  logic [VW-1:0] v_q;
  logic          ovf_q;
  logic [VW-1:0] recent_q [MAX_WINDOW];
  logic [RW-1:0] fill_q;
  logic [RW-1:0] win_q;
  logic [PAW-1:0] clr_q;

  // Ranking state
  logic [VW-1:0] i_q;
  logic [VW-1:0] j_q;
  logic [SW-1:0] s_q;
  logic [MW-1:0] prod_q;
  logic [AW-1:0] acc_q;
  logic [PW-1:0] dprod_q;
  logic [31:0]   maxd_q;
  logic [9:0]    iter_q;
  logic          sel_q;

  // Selection state
  logic [MAX_WORDS-1:0] picked_q;
  logic [31:0]          best_q;
  logic [VW-1:0]        bidx_q;
  logic                 have_q;
  logic [5:0]           p_q;

  // Result register
  logic     out_valid_q;
  cgr_out_t out_q;

  // RAM ports
  logic [VW-1:0]  key_addr;
  logic [31:0]    key_rd;
  logic [PAW-1:0] pair_addr;
  logic [15:0]    pair_wdata;
  logic [15:0]    pair_rd;
  logic [VW-1:0]  wt_addr;
  logic [SW-1:0]  wt_rd;
  logic [VW-1:0]  sc_addr;
  logic           sc_re;
  logic [31:0]    sc_wdata;
  logic           sca_we;
  logic           scb_we;
  logic [31:0]    sca_rd;
  logic [31:0]    scb_rd;
  logic [31:0]    sc_rd;

  // Combinational helpers
  logic [VW-1:0]  rv;
  logic [VW-1:0]  wlo;
  logic [VW-1:0]  whi;
  logic [VW-1:0]  ilo;
  logic [VW-1:0]  ihi;
  logic [4:0]     wl_m1;
  logic [SPW-1:0] sp_a;
  logic [SPW-1:0] sp_b;
  logic [SPW-1:0] sp_c;
  logic [RW-1:0]  span;
  logic [VW:0]    vc_m1;
  logic [AW-1:0]  dshift;
  logic [AW:0]    nv_full;
  logic [31:0]    nv;
  logic [31:0]    delta;
  logic [CNTW-1:0] lim;
  logic [CNTW-1:0] vce;
  logic [CNTW-1:0] count;
  logic [31:0]    quot;
  logic           div_done;

  // Window span: min(window_length - 1, MAX_WINDOW - 1, fill)
  assign wl_m1 = (wl_q == 5'd0) ? 5'd0 : wl_q - 5'd1;
  assign sp_a  = SPW'(wl_m1);
  assign sp_b  = (sp_a > SPW'(MAX_WINDOW - 1)) ? SPW'(MAX_WINDOW - 1) : sp_a;
  assign sp_c  = (sp_b > SPW'(fill_q)) ? SPW'(fill_q) : sp_b;
  assign span  = sp_c[RW-1:0];

  // Pair addresses, lower vertex first
  assign rv  = recent_q[win_q];
  assign wlo = (v_q < rv) ? v_q : rv;
  assign whi = (v_q < rv) ? rv : v_q;
  assign ilo = (i_q < j_q) ? i_q : j_q;
  assign ihi = (i_q < j_q) ? j_q : i_q;

  assign vc_m1 = vc_q - (VW + 1)'(1);

  // Rank update: (1 - d) + d * acc, saturated
  assign dshift  = dprod_q[PW-1:16];
  assign nv_full = {1'b0, dshift} + (AW + 1)'(ONE_Q16_17 - {1'b0, damp_q});
  assign nv      = (|nv_full[AW:32]) ? SCORE_MAX_32 : nv_full[31:0];
  assign delta   = (nv > sc_rd) ? nv - sc_rd : sc_rd - nv;

  // Result count: min(vertex count, clamped top count)
  assign lim   = (topc_q == 7'd0) ? CNTW'(1) :
                 (topc_q > TOP_LIMIT) ? CNTW'(TOP_LIMIT) : CNTW'(topc_q);
  assign vce   = CNTW'(vc_q);
  assign count = (vce < lim) ? vce : lim;

  // RAM address and data selection
  assign key_addr   = cmd_i.add_key ? vc_q[VW-1:0] :
                      cmd_i.out_rd  ? bidx_q : scan_q[VW-1:0];
  assign pair_addr  = cmd_i.clr_step ? clr_q :
                      (cmd_i.win_rd || cmd_i.win_bump) ? {wlo, whi} : {ilo, ihi};
  assign pair_wdata = cmd_i.clr_step ? 16'd0 :
                      (pair_rd == WEIGHT_MAX) ? WEIGHT_MAX : pair_rd + 16'd1;
  assign wt_addr    = cmd_i.sum_wr ? i_q : j_q;
  assign sc_addr    = cmd_i.it_rd ? j_q : i_q;
  assign sc_re      = cmd_i.it_rd || cmd_i.nv_rd || cmd_i.sel_rd;
  assign sc_wdata   = cmd_i.sum_wr ? ONE_Q16 : nv;
  assign sca_we     = (cmd_i.sum_wr && !sel_q) || (cmd_i.nv_wr && sel_q);
  assign scb_we     = (cmd_i.sum_wr && sel_q) || (cmd_i.nv_wr && !sel_q);
  assign sc_rd      = sel_q ? scb_rd : sca_rd;

  cgr_ram #(.WIDTH(32), .DEPTH(MAX_WORDS)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.add_key),
    .re_i    (cmd_i.srch_rd || cmd_i.out_rd),
    .addr_i  (key_addr),
    .wdata_i (key_q),
    .rdata_o (key_rd)
  );

  cgr_ram #(.WIDTH(16), .DEPTH(PDEP)) u_pair_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr_step || cmd_i.win_bump),
    .re_i    (cmd_i.win_rd || cmd_i.pair_rd_ij || cmd_i.it_rd),
    .addr_i  (pair_addr),
    .wdata_i (pair_wdata),
    .rdata_o (pair_rd)
  );

  cgr_ram #(.WIDTH(SW), .DEPTH(MAX_WORDS)) u_wt_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.sum_wr),
    .re_i    (cmd_i.it_rd),
    .addr_i  (wt_addr),
    .wdata_i (s_q),
    .rdata_o (wt_rd)
  );

  cgr_ram #(.WIDTH(32), .DEPTH(MAX_WORDS)) u_sca_ram (
    .clk_i   (clk_i),
    .we_i    (sca_we),
    .re_i    (sc_re),
    .addr_i  (sc_addr),
    .wdata_i (sc_wdata),
    .rdata_o (sca_rd)
  );

  cgr_ram #(.WIDTH(32), .DEPTH(MAX_WORDS)) u_scb_ram (
    .clk_i   (clk_i),
    .we_i    (scb_we),
    .re_i    (sc_re),
    .addr_i  (sc_addr),
    .wdata_i (sc_wdata),
    .rdata_o (scb_rd)
  );

  cgr_div #(.DVD_W(MW), .DSR_W(SW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (wt_rd),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q    <= RST_WINDOW_LENGTH;
      damp_q  <= RST_DAMPING;
      maxit_q <= RST_MAX_ITERATIONS;
      least_q <= RST_LEAST_DELTA;
      topc_q  <= RST_TOP_COUNT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WINDOW_LENGTH:  wl_q    <= cfg_data_i[4:0];
        CFG_DAMPING:        damp_q  <= cfg_data_i;
        CFG_MAX_ITERATIONS: maxit_q <= cfg_data_i[9:0];
        CFG_LEAST_DELTA:    least_q <= cfg_data_i;
        CFG_TOP_COUNT:      topc_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Document control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q     <= '0;
      fill_q   <= '0;
      ovf_q    <= 1'b0;
      iter_q   <= '0;
      clr_q    <= '0;
      sel_q    <= 1'b0;
      picked_q <= '0;
      have_q   <= 1'b0;
      p_q      <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + PAW'(1);
      end
      if (cmd_i.add_key) begin
        vc_q <= vc_q + (VW + 1)'(1);
      end
      if (cmd_i.set_ovf) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.shift && fill_q != RW'(MAX_WINDOW - 1)) begin
        fill_q <= fill_q + RW'(1);
      end
      if (cmd_i.it_init) begin
        iter_q <= '0;
      end
      if (cmd_i.iter_end) begin
        iter_q <= iter_q + 10'd1;
        sel_q  <= ~sel_q;
      end
      if (cmd_i.sel_init) begin
        picked_q <= '0;
        have_q   <= 1'b0;
        p_q      <= '0;
      end
      if (cmd_i.sel_cmp && !picked_q[i_q] && (!have_q || sc_rd > best_q)) begin
        have_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        picked_q[bidx_q] <= 1'b1;
        have_q           <= 1'b0;
        p_q              <= p_q + 6'd1;
      end
      if (cmd_i.doc_clear) begin
        vc_q   <= '0;
        fill_q <= '0;
        ovf_q  <= 1'b0;
        iter_q <= '0;
      end
    end
  end

  // Token and ranking payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      key_q  <= in_beat_i.word_key;
      eod_q  <= in_beat_i.end_of_document;
      scan_q <= '0;
    end
    if (cmd_i.scan_inc) begin
      scan_q <= scan_q + (VW + 1)'(1);
    end
    if (cmd_i.hit) begin
      v_q   <= scan_q[VW-1:0];
      win_q <= '0;
    end
    if (cmd_i.add_key) begin
      v_q   <= vc_q[VW-1:0];
      win_q <= '0;
    end
    if (cmd_i.win_skip || cmd_i.win_bump) begin
      win_q <= win_q + RW'(1);
    end
    if (cmd_i.shift) begin
      for (int k = MAX_WINDOW - 1; k > 0; k--) begin
        recent_q[k] <= recent_q[k-1];
      end
      recent_q[0] <= v_q;
    end
    // Weight sums
    if (cmd_i.sum_init) begin
      i_q <= '0;
      j_q <= '0;
      s_q <= '0;
    end
    if (cmd_i.sum_acc) begin
      s_q <= s_q + ((i_q != j_q) ? SW'(pair_rd) : SW'(0));
      j_q <= j_q + VW'(1);
    end
    if (cmd_i.sum_wr) begin
      s_q <= '0;
      j_q <= '0;
      i_q <= i_q + VW'(1);
    end
    // Rank rounds
    if (cmd_i.it_init) begin
      i_q    <= '0;
      j_q    <= '0;
      acc_q  <= '0;
      maxd_q <= '0;
    end
    if (cmd_i.mul) begin
      prod_q <= MW'(pair_rd) * MW'(sc_rd);
    end
    if (cmd_i.acc_add) begin
      acc_q <= acc_q + AW'(quot);
    end
    if (cmd_i.j_step) begin
      j_q <= j_q + VW'(1);
    end
    if (cmd_i.nv_rd) begin
      dprod_q <= PW'(damp_q) * PW'(acc_q);
    end
    if (cmd_i.nv_wr) begin
      if (delta > maxd_q) begin
        maxd_q <= delta;
      end
      acc_q <= '0;
      j_q   <= '0;
      i_q   <= i_q + VW'(1);
    end
    if (cmd_i.iter_end) begin
      i_q    <= '0;
      maxd_q <= '0;
    end
    // Selection scan
    if (cmd_i.sel_init) begin
      i_q <= '0;
    end
    if (cmd_i.sel_cmp) begin
      if (!picked_q[i_q] && (!have_q || sc_rd > best_q)) begin
        best_q <= sc_rd;
        bidx_q <= i_q;
      end
      i_q <= i_q + VW'(1);
    end
    if (cmd_i.out_load) begin
      i_q <= '0;
    end
  end

  // Result register, freed when the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.ranked_key       <= key_rd;
      out_q.rank_score       <= (|best_q[31:24]) ? SCORE_MAX_24 : best_q[23:0];
      out_q.rank_position    <= p_q;
      out_q.table_overflowed <= ovf_q;
      out_q.final_entry      <= sts_o.p_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  // Status to the controller
  always_comb begin
    sts_o           = '0;
    sts_o.clr_last  = &clr_q;
    sts_o.scan_end  = scan_q == vc_q;
    sts_o.key_match = key_rd == key_q;
    sts_o.full      = vc_q == (VW + 1)'(MAX_WORDS);
    sts_o.win_end   = win_q == span;
    sts_o.win_same  = rv == v_q;
    sts_o.eod       = eod_q;
    sts_o.i_last    = {1'b0, i_q} == vc_m1;
    sts_o.j_last    = {1'b0, j_q} == vc_m1;
    sts_o.term_ok   = (pair_rd != 16'd0) && (wt_rd != SW'(0)) && (i_q != j_q);
    sts_o.div_done  = div_done;
    sts_o.iter_zero = maxit_q == 10'd0;
    sts_o.iter_stop = ({1'b0, iter_q} + 11'd1 == {1'b0, maxit_q}) ||
                      (maxd_q < {16'd0, least_q});
    sts_o.p_last    = CNTW'(p_q) + CNTW'(1) == count;
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

endmodule

`default_nettype wire

>>> hdl/cgr_ctrl.sv
// Controller state machine sequencing token intake, ranking and result output.
`timescale 1ns / 1ps
`default_nettype none

module cgr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire cgr_pkg::cgr_sts_t sts_i,
  output      cgr_pkg::cgr_cmd_t cmd_o
);

  import cgr_pkg::*;

  localparam logic [4:0] ST_CLR      = 5'd0;
  localparam logic [4:0] ST_IDLE     = 5'd1;
  localparam logic [4:0] ST_SRCH_RD  = 5'd2;
  localparam logic [4:0] ST_SRCH_CMP = 5'd3;
  localparam logic [4:0] ST_WIN_RD   = 5'd4;
  localparam logic [4:0] ST_WIN_WR   = 5'd5;
  localparam logic [4:0] ST_DOC_CHK  = 5'd6;
  localparam logic [4:0] ST_SUM_RD   = 5'd7;
  localparam logic [4:0] ST_SUM_ACC  = 5'd8;
  localparam logic [4:0] ST_SUM_WR   = 5'd9;
  localparam logic [4:0] ST_IT_INIT  = 5'd10;
  localparam logic [4:0] ST_IT_RD    = 5'd11;
  localparam logic [4:0] ST_IT_CHK   = 5'd12;
  localparam logic [4:0] ST_DIV_GO   = 5'd13;
  localparam logic [4:0] ST_DIV_WAIT = 5'd14;
  localparam logic [4:0] ST_NV_RD    = 5'd15;
  localparam logic [4:0] ST_NV_WR    = 5'd16;
  localparam logic [4:0] ST_IT_END   = 5'd17;
  localparam logic [4:0] ST_SEL_INIT = 5'd18;
  localparam logic [4:0] ST_SEL_RD   = 5'd19;
  localparam logic [4:0] ST_SEL_CMP  = 5'd20;
  localparam logic [4:0] ST_OUT_RD   = 5'd21;
  localparam logic [4:0] ST_OUT_LD   = 5'd22;

  logic [4:0] state_q;
  logic [4:0] state_d;

  // State register; reset starts with the weight clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_o.idle = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        if (sts_i.scan_end) begin
          if (sts_i.full) begin
            cmd_o.set_ovf = 1'b1;
            state_d       = ST_DOC_CHK;
          end else begin
            cmd_o.add_key = 1'b1;
            state_d       = ST_WIN_RD;
          end
        end else begin
          cmd_o.srch_rd = 1'b1;
          state_d       = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: begin
        if (sts_i.key_match) begin
          cmd_o.hit = 1'b1;
          state_d   = ST_WIN_RD;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d        = ST_SRCH_RD;
        end
      end
      ST_WIN_RD: begin
        if (sts_i.win_end) begin
          cmd_o.shift = 1'b1;
          state_d     = ST_DOC_CHK;
        end else if (sts_i.win_same) begin
          cmd_o.win_skip = 1'b1;
        end else begin
          cmd_o.win_rd = 1'b1;
          state_d      = ST_WIN_WR;
        end
      end
      ST_WIN_WR: begin
        cmd_o.win_bump = 1'b1;
        state_d        = ST_WIN_RD;
      end
      ST_DOC_CHK: begin
        if (sts_i.eod) begin
          cmd_o.sum_init = 1'b1;
          state_d        = ST_SUM_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SUM_RD: begin
        cmd_o.pair_rd_ij = 1'b1;
        state_d          = ST_SUM_ACC;
      end
      ST_SUM_ACC: begin
        cmd_o.sum_acc = 1'b1;
        state_d       = sts_i.j_last ? ST_SUM_WR : ST_SUM_RD;
      end
      ST_SUM_WR: begin
        cmd_o.sum_wr = 1'b1;
        state_d      = sts_i.i_last ? ST_IT_INIT : ST_SUM_RD;
      end
      ST_IT_INIT: begin
        cmd_o.it_init = 1'b1;
        state_d       = sts_i.iter_zero ? ST_SEL_INIT : ST_IT_RD;
      end
      ST_IT_RD: begin
        cmd_o.it_rd = 1'b1;
        state_d     = ST_IT_CHK;
      end
      ST_IT_CHK: begin
        if (sts_i.term_ok) begin
          cmd_o.mul = 1'b1;
          state_d   = ST_DIV_GO;
        end else begin
          cmd_o.j_step = 1'b1;
          state_d      = sts_i.j_last ? ST_NV_RD : ST_IT_RD;
        end
      end
      ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.acc_add = 1'b1;
          cmd_o.j_step  = 1'b1;
          state_d       = sts_i.j_last ? ST_NV_RD : ST_IT_RD;
        end
      end
      ST_NV_RD: begin
        cmd_o.nv_rd = 1'b1;
        state_d     = ST_NV_WR;
      end
      ST_NV_WR: begin
        cmd_o.nv_wr = 1'b1;
        state_d     = sts_i.i_last ? ST_IT_END : ST_IT_RD;
      end
      ST_IT_END: begin
        cmd_o.iter_end = 1'b1;
        state_d        = sts_i.iter_stop ? ST_SEL_INIT : ST_IT_RD;
      end
      ST_SEL_INIT: begin
        cmd_o.sel_init = 1'b1;
        state_d        = ST_SEL_RD;
      end
      ST_SEL_RD: begin
        cmd_o.sel_rd = 1'b1;
        state_d      = ST_SEL_CMP;
      end
      ST_SEL_CMP: begin
        cmd_o.sel_cmp = 1'b1;
        state_d       = sts_i.i_last ? ST_OUT_RD : ST_SEL_RD;
      end
      ST_OUT_RD: begin
        cmd_o.out_rd = 1'b1;
        state_d      = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        // Hold until the result register is free
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.p_last) begin
            cmd_o.doc_clear = 1'b1;
            state_d         = ST_CLR;
          end else begin
            state_d = ST_SEL_RD;
          end
        end
      end
      default: begin
        state_d = ST_CLR;
      end
    endcase
  end

endmodule

`default_nettype wire
